>>> rtl/nfps_pkg.sv
`timescale 1ns / 1ps

package nfps_pkg;

  // list geometry and field widths
  localparam int unsigned SLOTS = 4;
  localparam int unsigned NUM_W = 12;
  localparam int unsigned DIST_W = 50;
  localparam int unsigned MAG_W = DIST_W / 2;
  localparam int unsigned SUM_W = DIST_W + 2;
  localparam logic [DIST_W-1:0] DIST_SAT = '1;

  // depth of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // configuration port
  localparam int unsigned APB_DW = 32;
  localparam int unsigned APB_AW = 4;
  localparam int unsigned REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_X = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_Y = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_QUERY_Z = 2'd2;

  // per-point bookkeeping decided at accept time
  typedef struct packed {
    logic [NUM_W-1:0] number;
    logic             first;
    logic             part;
    logic             last;
    logic             ovf;
  } tag_t;

  // classified point handed from front to back
  typedef struct packed {
    tag_t              tag;
    logic [DIST_W-1:0] dist_sq;
  } item_t;

endpackage

>>> rtl/nearest_four_points_select_top.sv
`timescale 1ns / 1ps
// a result is registered once the closing request has passed the front stages and the queue
// throughput: one point per cycle; the distance pipeline, queue and compare-insert all
// sustain one request per cycle, and a closing request waits only on a full output register
// reset: asynchronous, active low; clears query registers, point count, set state,
// best list, queue and pipeline valid flags; no clearing pass is needed

module nearest_four_points_select_top #(
  parameter int unsigned MAX_NODES  = 4096,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nfps_pkg::APB_AW-1:0]       paddr,
  input  logic [nfps_pkg::APB_DW-1:0]       pwdata,
  output logic [nfps_pkg::APB_DW-1:0]       prdata,
  output logic                              pready,
  // point stream
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      point_x_i,
  input  logic signed [COORD_BITS-1:0]      point_y_i,
  input  logic signed [COORD_BITS-1:0]      point_z_i,
  input  logic                              last_point_i,
  // result stream
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [nfps_pkg::NUM_W-1:0]        nearest_index_0_o,
  output logic [nfps_pkg::NUM_W-1:0]        nearest_index_1_o,
  output logic [nfps_pkg::NUM_W-1:0]        nearest_index_2_o,
  output logic [nfps_pkg::NUM_W-1:0]        nearest_index_3_o,
  output logic [nfps_pkg::DIST_W-1:0]       nearest_dist_0_o,
  output logic [nfps_pkg::DIST_W-1:0]       nearest_dist_1_o,
  output logic [nfps_pkg::DIST_W-1:0]       nearest_dist_2_o,
  output logic [nfps_pkg::DIST_W-1:0]       nearest_dist_3_o,
  output logic                              count_overflow_o
);

  logic signed [COORD_BITS-1:0]   qx_q, qy_q, qz_q;
  logic                           cfg_wr;
  logic [nfps_pkg::REG_IDX_W-1:0] reg_idx;

  logic                           fq_valid, fq_ready;
  nfps_pkg::item_t                fq_item;
  logic                           qb_valid, qb_ready;
  nfps_pkg::item_t                qb_item;

  logic [nfps_pkg::NUM_W-1:0]     out_num [nfps_pkg::SLOTS];
  logic [nfps_pkg::DIST_W-1:0]    out_dist [nfps_pkg::SLOTS];

  // query registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[nfps_pkg::APB_AW-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qx_q <= '0;
      qy_q <= '0;
      qz_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        nfps_pkg::REG_QUERY_X: qx_q <= pwdata[COORD_BITS-1:0];
        nfps_pkg::REG_QUERY_Y: qy_q <= pwdata[COORD_BITS-1:0];
        nfps_pkg::REG_QUERY_Z: qz_q <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      nfps_pkg::REG_QUERY_X: prdata = nfps_pkg::APB_DW'(qx_q);
      nfps_pkg::REG_QUERY_Y: prdata = nfps_pkg::APB_DW'(qy_q);
      nfps_pkg::REG_QUERY_Z: prdata = nfps_pkg::APB_DW'(qz_q);
      default:               prdata = '0;
    endcase
  end

  // numbering and distance pipeline
  nfps_front #(
    .MAX_NODES  (MAX_NODES),
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .point_z_i    (point_z_i),
    .last_point_i (last_point_i),
    .query_x_i    (qx_q),
    .query_y_i    (qy_q),
    .query_z_i    (qz_q),
    .item_valid_o (fq_valid),
    .item_ready_i (fq_ready),
    .item_o       (fq_item)
  );

  // decoupling queue
  nfps_queue #(
    .DEPTH (nfps_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_item_i  (fq_item),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_item_o   (qb_item)
  );

  // sorted list and result register
  nfps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (qb_valid),
    .item_ready_o (qb_ready),
    .item_i       (qb_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_num_o    (out_num),
    .out_dist_o   (out_dist),
    .out_ovf_o    (count_overflow_o)
  );

  assign nearest_index_0_o = out_num[0];
  assign nearest_index_1_o = out_num[1];
  assign nearest_index_2_o = out_num[2];
  assign nearest_index_3_o = out_num[3];
  assign nearest_dist_0_o  = out_dist[0];
  assign nearest_dist_1_o  = out_dist[1];
  assign nearest_dist_2_o  = out_dist[2];
  assign nearest_dist_3_o  = out_dist[3];

endmodule

>>> rtl/nfps_front.sv
`timescale 1ns / 1ps

module nfps_front #(
  parameter int unsigned MAX_NODES  = 4096,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [COORD_BITS-1:0] point_x_i,
  input  logic signed [COORD_BITS-1:0] point_y_i,
  input  logic signed [COORD_BITS-1:0] point_z_i,
  input  logic                         last_point_i,
  input  logic signed [COORD_BITS-1:0] query_x_i,
  input  logic signed [COORD_BITS-1:0] query_y_i,
  input  logic signed [COORD_BITS-1:0] query_z_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output nfps_pkg::item_t              item_o
);

  localparam int unsigned CNT_W = $clog2(MAX_NODES + 2);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_NODES);
  localparam int unsigned DIFF_W = COORD_BITS + 1;
  localparam int unsigned EXT_W =
    (DIFF_W > nfps_pkg::MAG_W) ? DIFF_W : nfps_pkg::MAG_W + 1;

  logic                           in_fire;
  logic                           adv1, adv2, adv3;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic                           started_q, started_d;
  nfps_pkg::tag_t                 tag_in;

  logic signed [COORD_BITS-1:0]   pt [3];
  logic signed [COORD_BITS-1:0]   qr [3];
  logic signed [DIFF_W-1:0]       diff [3];
  logic [DIFF_W-1:0]              mag [3];
  logic [EXT_W-1:0]               mag_ext [3];
  logic                           sat [3];

  logic                           v1_q, v2_q, v3_q;
  nfps_pkg::tag_t                 tag1_q, tag2_q, tag3_q;
  logic [nfps_pkg::MAG_W-1:0]     mag1_q [3];
  logic                           sat1_q [3];
  logic [nfps_pkg::DIST_W-1:0]    prod [3];
  logic [nfps_pkg::DIST_W-1:0]    sq2_q [3];
  logic [nfps_pkg::SUM_W-1:0]     sum;
  logic [nfps_pkg::DIST_W-1:0]    dist3_d, dist3_q;

  // pipeline advance, back to front
  assign adv3       = !v3_q || item_ready_i;
  assign adv2       = !v2_q || adv3;
  assign adv1       = !v1_q || adv2;
  assign in_ready_o = adv1;
  assign in_fire    = in_valid_i && in_ready_o;

  // numbering and classification of the accepted point
  always_comb begin
    tag_in.number = nfps_pkg::NUM_W'(cnt_q);
    tag_in.first  = !started_q;
    tag_in.part   = cnt_q < MAX_CNT;
    tag_in.last   = last_point_i;
    tag_in.ovf    = cnt_q >= MAX_CNT;
    if (last_point_i) begin
      cnt_d     = '0;
      started_d = 1'b0;
    end else begin
      cnt_d     = (cnt_q <= MAX_CNT) ? cnt_q + 1'b1 : cnt_q;
      started_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else if (in_fire) begin
      cnt_q     <= cnt_d;
      started_q <= started_d;
    end
  end

  // per-axis difference magnitude and saturation flag
  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;
  assign qr[0] = query_x_i;
  assign qr[1] = query_y_i;
  assign qr[2] = query_z_i;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      diff[a]    = $signed({pt[a][COORD_BITS-1], pt[a]})
                 - $signed({qr[a][COORD_BITS-1], qr[a]});
      mag[a]     = diff[a][DIFF_W-1] ? DIFF_W'(-diff[a]) : DIFF_W'(diff[a]);
      mag_ext[a] = EXT_W'(mag[a]);
      sat[a]     = |mag_ext[a][EXT_W-1:nfps_pkg::MAG_W];
    end
  end

  // stage 1: magnitudes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv1) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      tag1_q <= tag_in;
      for (int a = 0; a < 3; a++) begin
        mag1_q[a] <= mag_ext[a][nfps_pkg::MAG_W-1:0];
        sat1_q[a] <= sat[a];
      end
    end
  end

  // stage 2: squares
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod[a] = mag1_q[a] * mag1_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv2) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && v1_q) begin
      tag2_q <= tag1_q;
      for (int a = 0; a < 3; a++) begin
        sq2_q[a] <= sat1_q[a] ? nfps_pkg::DIST_SAT : prod[a];
      end
    end
  end

  // stage 3: saturating sum
  always_comb begin
    sum = nfps_pkg::SUM_W'(sq2_q[0]) + nfps_pkg::SUM_W'(sq2_q[1])
        + nfps_pkg::SUM_W'(sq2_q[2]);
    dist3_d = (|sum[nfps_pkg::SUM_W-1:nfps_pkg::DIST_W]) ? nfps_pkg::DIST_SAT
                                                          : sum[nfps_pkg::DIST_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv3) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv3 && v2_q) begin
      tag3_q  <= tag2_q;
      dist3_q <= dist3_d;
    end
  end

  assign item_valid_o   = v3_q;
  assign item_o.tag     = tag3_q;
  assign item_o.dist_sq = dist3_q;

`ifndef SYNTHESIS
  // a closing point restarts numbering for the next set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_point_i) |=> (cnt_q == '0 && !started_q))
    else $error("set counter not cleared after last point");

  // a stalled output stage keeps its distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !item_ready_i) |=> (v3_q && $stable(dist3_q)))
    else $error("front output changed while stalled");
`endif

endmodule

>>> rtl/nfps_queue.sv
`timescale 1ns / 1ps

module nfps_queue #(
  parameter int unsigned DEPTH = nfps_pkg::QUEUE_DEPTH
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  nfps_pkg::item_t push_item_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output nfps_pkg::item_t pop_item_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  nfps_pkg::item_t  mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             push, pop;

  assign push_ready_o = count_q != FULL_CNT;
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  // fill level never exceeds the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("queue overfilled");

  // a lone push raises the fill level by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 1'b1))
    else $error("queue fill level lost a request");
`endif

endmodule

>>> rtl/nfps_back.sv
`timescale 1ns / 1ps

module nfps_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        item_valid_i,
  output logic                        item_ready_o,
  input  nfps_pkg::item_t             item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [nfps_pkg::NUM_W-1:0]  out_num_o [nfps_pkg::SLOTS],
  output logic [nfps_pkg::DIST_W-1:0] out_dist_o [nfps_pkg::SLOTS],
  output logic                        out_ovf_o
);

  logic [nfps_pkg::DIST_W-1:0] dist_q [nfps_pkg::SLOTS];
  logic [nfps_pkg::DIST_W-1:0] dist_d [nfps_pkg::SLOTS];
  logic [nfps_pkg::NUM_W-1:0]  num_q [nfps_pkg::SLOTS];
  logic [nfps_pkg::NUM_W-1:0]  num_d [nfps_pkg::SLOTS];
  logic                        cmp [nfps_pkg::SLOTS];
  logic                        ins;
  logic                        pop;
  logic                        out_valid_q;
  logic [nfps_pkg::DIST_W-1:0] out_dist_q [nfps_pkg::SLOTS];
  logic [nfps_pkg::NUM_W-1:0]  out_num_q [nfps_pkg::SLOTS];
  logic                        out_ovf_q;

  // a closing request waits only while the output register is full
  assign item_ready_o = !item_i.tag.last || !out_valid_q || out_ready_i;
  assign pop          = item_valid_i && item_ready_o;

  // parallel compare against all slots
  always_comb begin
    for (int i = 0; i < nfps_pkg::SLOTS; i++) begin
      cmp[i] = item_i.dist_sq < dist_q[i];
    end
    ins = item_i.tag.part && cmp[nfps_pkg::SLOTS-1];
  end

  // first point fills every slot; later ones insert with shift-down; earlier points stay ahead on ties
  always_comb begin
    dist_d = dist_q;
    num_d  = num_q;
    if (item_i.tag.first) begin
      for (int i = 0; i < nfps_pkg::SLOTS; i++) begin
        dist_d[i] = item_i.dist_sq;
        num_d[i]  = '0;
      end
    end else if (ins) begin
      if (cmp[0]) begin
        dist_d[0] = item_i.dist_sq;
        num_d[0]  = item_i.tag.number;
      end
      for (int i = 1; i < nfps_pkg::SLOTS; i++) begin
        if (cmp[i-1]) begin
          dist_d[i] = dist_q[i-1];
          num_d[i]  = num_q[i-1];
        end else if (cmp[i]) begin
          dist_d[i] = item_i.dist_sq;
          num_d[i]  = item_i.tag.number;
        end
      end
    end
  end

  // best list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < nfps_pkg::SLOTS; i++) begin
        dist_q[i] <= '0;
        num_q[i]  <= '0;
      end
    end else if (pop) begin
      dist_q <= dist_d;
      num_q  <= num_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop && item_i.tag.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && item_i.tag.last) begin
      out_dist_q <= dist_d;
      out_num_q  <= num_d;
      out_ovf_q  <= item_i.tag.ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dist_o  = out_dist_q;
  assign out_num_o   = out_num_q;
  assign out_ovf_o   = out_ovf_q;

`ifndef SYNTHESIS
  // the list stays in ascending order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_q[0] <= dist_q[1]) && (dist_q[1] <= dist_q[2]) && (dist_q[2] <= dist_q[3]))
    else $error("best list out of order");

  // the first point of a set leaves equal distances in the end slots and number zero in the last
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && item_i.tag.first) |=>
      (dist_q[0] == dist_q[nfps_pkg::SLOTS-1] && num_q[nfps_pkg::SLOTS-1] == '0))
    else $error("first point did not fill the list");
`endif

endmodule
